>>> rtl/c2r_pkg.sv
// Shared constants, mode codes and arctangent table of the complex-to-real converter
`default_nettype none

package c2r_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int GUARD        = 2;
   localparam int ATAN_ENTRIES = 24;

   localparam int FIELD_W = 16;
   localparam int VALUE_W = 33;

   localparam int XW     = SAMPLE_BITS + GUARD + 4;
   localparam int ZW     = 34;
   localparam int PH_W   = ZW - 16;
   localparam int SQ_W   = 2 * SAMPLE_BITS;

   localparam int                 INV_GAIN_W = 30;
   localparam logic [INV_GAIN_W-1:0] INV_GAIN = 30'd652032875;
   localparam int                 PROD_W     = XW - 1 + INV_GAIN_W;
   localparam int                 AMP_SHIFT  = 30 + GUARD;
   localparam logic [PROD_W:0]    AMP_ROUND  = (PROD_W + 1)'(64'd1 << (29 + GUARD));
   localparam logic signed [ZW-1:0] PH_ROUND = ZW'(32768);

   localparam int POW_SHIFT = 2 * (SAMPLE_BITS - 16);
   localparam int POW_SHR   = (POW_SHIFT > 0) ? POW_SHIFT : 0;
   localparam int POW_SHL   = (POW_SHIFT < 0) ? -POW_SHIFT : 0;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic MODE_INDEX = 1'b0;

   localparam logic [2:0] MODE_REAL  = 3'd0;
   localparam logic [2:0] MODE_IMAG  = 3'd1;
   localparam logic [2:0] MODE_POWER = 3'd2;
   localparam logic [2:0] MODE_AMPL  = 3'd3;
   localparam logic [2:0] MODE_PHASE = 3'd4;

   typedef logic signed [ZW-1:0] angle_type;

   localparam angle_type ATAN_TABLE [ATAN_ENTRIES] = '{
      34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
      34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
      34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
      34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D,
      34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
      34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051
   };

   localparam angle_type HALF_PI = ATAN_TABLE[0] <<< 1;

endpackage

`default_nettype wire

>>> rtl/c2r_ifs.sv
// Stream interfaces carrying complex sample words in and converted value words out
`default_nettype none

interface c2r_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [c2r_pkg::FIELD_W-1:0]     re_part;
   logic signed [c2r_pkg::FIELD_W-1:0]     im_part;

   modport source (output valid, output re_part, output im_part, input ready);
   modport sink   (input valid, input re_part, input im_part, output ready);
endinterface

interface c2r_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [c2r_pkg::VALUE_W-1:0]     value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/complex_to_real_converter.sv
// Top level: pipelined complex-to-real converter with vectoring CORDIC and mode register
// Throughput: one word per cycle; the whole pipeline advances together, so a stalled
// output holds every stage and nothing is lost or repeated. Depth is set by the entry
// register, the fold/square stage, 16 CORDIC stages, the gain multiplier stage and the
// output register. Reset (synchronous) clears all stage valid bits and sets mode to real.
`default_nettype none

module complex_to_real_converter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   c2r_req_if.sink                              req,
   c2r_rsp_if.source                            rsp,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [c2r_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [c2r_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [c2r_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);

   import c2r_pkg::*;

   localparam int N = CORDIC_STEPS;

   logic [2:0] mode_ff, mode_in;
   logic       adv;

   // entry stage
   logic                          e_vld_ff;
   logic signed [SAMPLE_BITS-1:0] e_re_ff, e_im_ff;
   logic [2:0]                    e_mode_ff;

   // fold and square stage, then CORDIC stages
   logic                          s_vld_ff  [0:N];
   logic [2:0]                    s_mode_ff [0:N];
   logic                          s_zero_ff [0:N];
   logic signed [XW-1:0]          x_ff      [0:N];
   logic signed [XW-1:0]          y_ff      [0:N];
   angle_type                     z_ff      [0:N];
   logic signed [VALUE_W-1:0]     side_ff   [1:N];
   logic [SQ_W-1:0]               sqr_ff, sqi_ff;
   logic signed [SAMPLE_BITS-1:0] s0_re_ff, s0_im_ff;

   logic signed [XW-1:0]          x_in      [0:N];
   logic signed [XW-1:0]          y_in      [0:N];
   angle_type                     z_in      [0:N];
   logic signed [VALUE_W-1:0]     side_in;
   logic signed [SQ_W-1:0]        sqr_in, sqi_in;
   logic signed [XW-1:0]          r_ext, q_ext;

   // gain stage
   logic                          m_vld_ff;
   logic [2:0]                    m_mode_ff;
   logic                          m_zero_ff;
   logic [PROD_W-1:0]             m_prod_ff, m_prod_in;
   logic signed [PH_W-1:0]        m_phase_ff, m_phase_in;
   logic signed [VALUE_W-1:0]     m_side_ff;
   angle_type                     ph_sum;

   // output register
   logic                          o_vld_ff;
   logic signed [VALUE_W-1:0]     o_value_ff, o_value_in;
   logic [PROD_W:0]               amp_sum;
   logic [63:0]                   pwr_wide, pwr_scaled;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && paddr[CSR_ADDR_W-1] == MODE_INDEX) begin
         mode_in = pwdata[2:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == MODE_INDEX) begin
         prdata = CSR_DATA_W'(mode_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_REAL;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // ---------------- flow control ----------------
   assign adv       = !o_vld_ff || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_re_ff   <= req.re_part[SAMPLE_BITS-1:0];
         e_im_ff   <= req.im_part[SAMPLE_BITS-1:0];
         e_mode_ff <= mode_ff;
      end
   end

   // ---------------- quadrant fold and squares ----------------
   assign r_ext  = {{(XW-SAMPLE_BITS-GUARD){e_re_ff[SAMPLE_BITS-1]}}, e_re_ff, {GUARD{1'b0}}};
   assign q_ext  = {{(XW-SAMPLE_BITS-GUARD){e_im_ff[SAMPLE_BITS-1]}}, e_im_ff, {GUARD{1'b0}}};
   assign sqr_in = e_re_ff * e_re_ff;
   assign sqi_in = e_im_ff * e_im_ff;

   always_comb begin
      if (e_re_ff < 0 && e_im_ff >= 0) begin
         x_in[0] = q_ext;
         y_in[0] = -r_ext;
         z_in[0] = HALF_PI;
      end else if (e_re_ff < 0) begin
         x_in[0] = -q_ext;
         y_in[0] = r_ext;
         z_in[0] = -HALF_PI;
      end else begin
         x_in[0] = r_ext;
         y_in[0] = q_ext;
         z_in[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         s_vld_ff[0] <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]      <= x_in[0];
         y_ff[0]      <= y_in[0];
         z_ff[0]      <= z_in[0];
         s_mode_ff[0] <= e_mode_ff;
         s_zero_ff[0] <= (e_re_ff == 0) && (e_im_ff == 0);
         sqr_ff       <= sqr_in;
         sqi_ff       <= sqi_in;
         s0_re_ff     <= e_re_ff;
         s0_im_ff     <= e_im_ff;
      end
   end

   // ---------------- side value: parts or power ----------------
   assign pwr_wide   = 64'(sqr_ff) + 64'(sqi_ff);
   assign pwr_scaled = (pwr_wide >> POW_SHR) << POW_SHL;

   always_comb begin
      case (s_mode_ff[0])
         MODE_REAL:  side_in = {{(VALUE_W-SAMPLE_BITS){s0_re_ff[SAMPLE_BITS-1]}}, s0_re_ff};
         MODE_IMAG:  side_in = {{(VALUE_W-SAMPLE_BITS){s0_im_ff[SAMPLE_BITS-1]}}, s0_im_ff};
         MODE_POWER: side_in = pwr_scaled[VALUE_W-1:0];
         default:    side_in = '0;
      endcase
   end

   // ---------------- CORDIC iterations, one per stage ----------------
   for (genvar i = 0; i < N; i++) begin : g_step
      always_comb begin
         if (!y_ff[i][XW-1]) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + ATAN_TABLE[i];
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            s_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            s_vld_ff[i+1] <= s_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i+1]      <= x_in[i+1];
            y_ff[i+1]      <= y_in[i+1];
            z_ff[i+1]      <= z_in[i+1];
            s_mode_ff[i+1] <= s_mode_ff[i];
            s_zero_ff[i+1] <= s_zero_ff[i];
         end
      end

      if (i == 0) begin : g_side_first
         always_ff @(posedge clock) begin
            if (adv) begin
               side_ff[1] <= side_in;
            end
         end
      end else begin : g_side_copy
         always_ff @(posedge clock) begin
            if (adv) begin
               side_ff[i+1] <= side_ff[i];
            end
         end
      end
   end

   // ---------------- gain correction and phase rounding ----------------
   assign m_prod_in  = PROD_W'(x_ff[N][XW-2:0]) * PROD_W'(INV_GAIN);
   assign ph_sum     = z_ff[N] + PH_ROUND;
   assign m_phase_in = ph_sum[ZW-1:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= s_vld_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_prod_ff  <= m_prod_in;
         m_phase_ff <= m_phase_in;
         m_side_ff  <= side_ff[N];
         m_mode_ff  <= s_mode_ff[N];
         m_zero_ff  <= s_zero_ff[N];
      end
   end

   // ---------------- output selection ----------------
   assign amp_sum = {1'b0, m_prod_ff} + AMP_ROUND;

   always_comb begin
      case (m_mode_ff) inside
         MODE_REAL, MODE_IMAG, MODE_POWER: o_value_in = m_side_ff;
         MODE_AMPL:  o_value_in = VALUE_W'(amp_sum[PROD_W:AMP_SHIFT]);
         MODE_PHASE: begin
            if (m_zero_ff) begin
               o_value_in = '0;
            end else begin
               o_value_in = {{(VALUE_W-PH_W){m_phase_ff[PH_W-1]}}, m_phase_ff};
            end
         end
         default:    o_value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         o_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_value_ff <= o_value_in;
      end
   end

   assign rsp.valid = o_vld_ff;
   assign rsp.value = o_value_ff;

   // ---------------- assertions ----------------
   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      s_vld_ff[N] |-> !x_ff[N][XW-1])
      else $error("CORDIC x went negative");

   a_zero_phase: assert property (@(posedge clock) disable iff (reset)
      adv && m_vld_ff && m_zero_ff && m_mode_ff == MODE_PHASE |=> rsp.value == '0)
      else $error("phase of zero input not zero");

   a_entry_moves: assert property (@(posedge clock) disable iff (reset)
      adv && e_vld_ff |=> s_vld_ff[0])
      else $error("entry word lost");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(m_vld_ff) && $stable(s_vld_ff[N]))
      else $error("pipeline moved during stall");

   a_unused_mode: assert property (@(posedge clock) disable iff (reset)
      adv && m_vld_ff && (m_mode_ff > MODE_PHASE)
      |=> rsp.value == '0)
      else $error("unused mode gave non-zero value");

endmodule

`default_nettype wire

>>> bench/c2r_value_check.sv
// Checker for the complex-to-real converter: tracks the mode, predicts each value word, compares
module c2r_value_check (
   input  wire logic                            clock,
   input  wire logic                            reset,
   c2r_req_if                                   req,
   c2r_rsp_if                                   rsp,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic                            pready,
   input  wire logic [c2r_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [c2r_pkg::CSR_DATA_W-1:0]  pwdata,
   output int                                   fail_count,
   output int                                   outstanding,
   output int                                   checked
);
   import c2r_pkg::*;

   localparam int ARCTAN_LEN = 24;
   localparam int MODE_REG   = 0;

   longint                 arctan_step [ARCTAN_LEN];
   logic [2:0]             mode_reg;
   logic [VALUE_W-1:0]     expected_values [$];
   logic [VALUE_W-1:0]     want;

   initial arctan_step = '{
      64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
      64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
      64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
      64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D,
      64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
      64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051
   };

   function automatic logic [VALUE_W-1:0] convert_sample(input logic [2:0] mode_sel,
                                                          input logic signed [FIELD_W-1:0] re_in,
                                                          input logic signed [FIELD_W-1:0] im_in);
      longint           re, im, x, y, z, dx, dy, result;
      longint unsigned  prod;
      re = re_in;
      im = im_in;
      result = 0;
      case (mode_sel)
         MODE_REAL:  result = re;
         MODE_IMAG:  result = im;
         MODE_POWER: result = ((re * re + im * im) >> POW_SHR) << POW_SHL;
         MODE_AMPL, MODE_PHASE: begin
            if (re < 0 && im >= 0) begin
               x = im <<< GUARD;
               y = -(re <<< GUARD);
               z = arctan_step[0] * 2;
            end else if (re < 0) begin
               x = -(im <<< GUARD);
               y = re <<< GUARD;
               z = -arctan_step[0] * 2;
            end else begin
               x = re <<< GUARD;
               y = im <<< GUARD;
               z = 0;
            end
            for (int i = 0; i < CORDIC_STEPS && i < ARCTAN_LEN; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (y >= 0) begin
                  x = x + dx;
                  y = y - dy;
                  z = z + arctan_step[i];
               end else begin
                  x = x - dx;
                  y = y + dy;
                  z = z - arctan_step[i];
               end
            end
            prod = x;
            prod = prod * 64'd652032875 + (64'd1 << (29 + GUARD));
            if (mode_sel == MODE_AMPL)
               result = longint'(prod >> (30 + GUARD));
            else if (re == 0 && im == 0)
               result = 0;
            else
               result = (z + 32768) >>> 16;
         end
         default: result = 0;
      endcase
      return result[VALUE_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_values.delete();
         mode_reg    <= MODE_REAL;
         outstanding <= 0;
         fail_count  <= 0;
         checked     <= 0;
      end else begin
         if (req.valid && req.ready)
            expected_values.push_back(convert_sample(mode_reg, req.re_part, req.im_part));
         if (rsp.valid && rsp.ready) begin
            checked <= checked + 1;
            if (expected_values.size() == 0) begin
               $error("value: unexpected word, expected none, actual %0d", $signed(rsp.value));
               fail_count <= fail_count + 1;
            end else begin
               want = expected_values.pop_front();
               if (rsp.value !== want) begin
                  $error("value: expected %0d, actual %0d", $signed(want), $signed(rsp.value));
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (psel && penable && pwrite && pready && (paddr >> 2) == MODE_REG)
            mode_reg <= pwdata[2:0];
         outstanding <= expected_values.size();
      end
   end

endmodule

>>> bench/tb_top.sv
// Top of the converter bench: clock, reset, sample and mode stimulus, flow control and verdict
module tb_top;
   import c2r_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;
   localparam logic [2:0] MODE_SPARE_A = 3'd5;
   localparam logic [2:0] MODE_SPARE_B = 3'd6;
   localparam logic [2:0] MODE_SPARE_C = 3'd7;
   localparam logic signed [FIELD_W-1:0] S_MAX = 16'sh7FFF;
   localparam logic signed [FIELD_W-1:0] S_MIN = 16'sh8000;
   localparam int HOLD_CYCLES = 60;

   logic                    clock;
   logic                    reset;
   logic                    psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata, prdata;
   int                      fail_count, outstanding, checked;
   int                      words_sent;
   int                      hold_asked, hold_served;
   bit                      send_gaps, recv_stalls;
   logic [2:0]              phase_mode;

   c2r_req_if req_bus ();
   c2r_rsp_if rsp_bus ();

   complex_to_real_converter dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   c2r_value_check value_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 500000);
      $display("tb: failure");
      $finish;
   end

   // result side: random stall bursts, long hold-off on request
   initial begin
      forever begin
         if (hold_served != hold_asked) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic signed [FIELD_W-1:0] pick_part();
      logic signed [FIELD_W-1:0] part;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: part = S_MIN;
               1: part = S_MAX;
               2: part = -1;
               3: part = 0;
               default: part = 1;
            endcase
         end
         1: part = $signed(FIELD_W'($urandom_range(0, 8))) - 4;
         default: part = FIELD_W'($urandom);
      endcase
      return part;
   endfunction

   task automatic send_word(input logic signed [FIELD_W-1:0] re, input logic signed [FIELD_W-1:0] im);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.re_part <= re;
      req_bus.im_part <= im;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++)
         send_word(pick_part(), pick_part());
   endtask

   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      drain_pipeline();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_mode(input logic [2:0] mode_sel);
      write_csr(MODE_ADDR, ($urandom & ~32'h7) | CSR_DATA_W'(mode_sel));
   endtask

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.re_part <= '0;
      req_bus.im_part <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      send_gaps        = 1'b0;
      recv_stalls      = 1'b0;
      words_sent       = 0;
      hold_asked       = 0;
      hold_served      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mode after reset is real
      send_word(S_MAX, S_MIN);
      send_word(S_MIN, S_MAX);
      write_mode(MODE_IMAG);
      send_word(S_MIN, S_MAX);
      send_word(S_MAX, S_MIN);
      write_mode(MODE_POWER);
      send_word(S_MIN, S_MIN);
      send_word(S_MAX, S_MAX);
      send_word(0, 0);
      write_mode(MODE_AMPL);
      send_word(S_MIN, S_MIN);
      send_word(S_MAX, 0);
      send_word(0, 0);
      send_word(-1, 1);
      write_mode(MODE_PHASE);
      send_word(0, 0);
      send_word(1, 0);
      send_word(0, 1);
      send_word(-1, 0);
      send_word(0, -1);
      send_word(S_MIN, 1);
      send_word(S_MIN, -1);
      send_word(-1, -1);
      send_word(S_MAX, S_MAX);
      write_mode(MODE_SPARE_A);
      send_word(1, 1);
      write_mode(MODE_SPARE_B);
      send_word(S_MAX, S_MIN);
      write_mode(MODE_SPARE_C);
      send_word(S_MIN, S_MAX);
      // a write to the unused address must leave the mode alone
      write_csr(SPARE_ADDR, CSR_DATA_W'(MODE_POWER));
      send_word(S_MIN, S_MIN);

      for (int ph = 0; ph < 12; ph++) begin
         phase_mode = (ph < 8) ? 3'(ph) : 3'($urandom_range(MODE_POWER, MODE_PHASE));
         write_mode(phase_mode);
         send_gaps   = (ph % 3 != 2);
         recv_stalls = (ph % 4 != 3);
         send_random((phase_mode > MODE_PHASE) ? 30 : 120);
      end

      // hold the result side while words keep coming, so the pipeline fills
      write_mode(MODE_PHASE);
      send_gaps   = 1'b0;
      recv_stalls = 1'b0;
      hold_asked++;
      send_random(80);

      write_mode(MODE_AMPL);
      send_random(80);

      drain_pipeline();
      repeat (40) @(posedge clock);
      $display("tb: %0d sample words over all mode codes, reset value and unused address,",
               words_sent);
      $display("tb: %0d value words compared, with stalls, gaps and a full-pipeline hold",
               checked);
      if (fail_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
